>>> rtl/asm_tok_pkg.sv
// Shared types, character codes and helpers for the assembly line tokenizer.
`default_nettype none
package asm_tok_pkg;

    // Parse states of the line machine.
    typedef enum logic [2:0] {
        ST_WAIT_START = 3'd0,
        ST_STATEMENT  = 3'd1,
        ST_EXPECT_END = 3'd2,
        ST_WAIT_ARG   = 3'd3,
        ST_ARG        = 3'd4,
        ST_STRING     = 3'd5,
        ST_WAIT_SEP   = 3'd6,
        ST_SKIP       = 3'd7
    } parse_state_t;

    // What is known so far about the kind of the current line.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_INSTR = 2'd1,
        KIND_LABEL = 2'd2,
        KIND_DIR   = 2'd3
    } line_kind_t;

    // Role tag given to each byte.
    typedef enum logic [2:0] {
        ROLE_SKIP   = 3'd0,
        ROLE_SSTART = 3'd1,
        ROLE_SBODY  = 3'd2,
        ROLE_ASTART = 3'd3,
        ROLE_ABODY  = 3'd4,
        ROLE_TERM   = 3'd5,
        ROLE_IGN    = 3'd6
    } char_role_t;

    // Line classification reported when a line is decided.
    typedef enum logic [2:0] {
        RES_EMPTY = 3'd0,
        RES_INSTR = 3'd1,
        RES_LABEL = 3'd2,
        RES_DIR   = 3'd3,
        RES_ERROR = 3'd4
    } line_result_t;

    // Configuration register indexes.
    localparam logic CFG_COMMENT   = 1'b0;
    localparam logic CFG_SEPARATOR = 1'b1;

    // Character codes.
    localparam logic [7:0] CHR_EOL         = 8'h00;
    localparam logic [7:0] CHR_DOT         = 8'h2E;
    localparam logic [7:0] CHR_COLON       = 8'h3A;
    localparam logic [7:0] CHR_QUOTE       = 8'h22;
    localparam logic [7:0] COMMENT_RESET   = 8'h3B;
    localparam logic [7:0] SEPARATOR_RESET = 8'h2C;

    localparam int ARG_W = 4;
    localparam logic [ARG_W-1:0] ARG_CAP = 4'd15;

    // State carried from one byte to the next.
    typedef struct packed {
        parse_state_t     parse;
        line_kind_t       kind;
        logic [ARG_W-1:0] arg_cnt;
    } tok_state_t;

    // Configuration seen by the step logic.
    typedef struct packed {
        logic [7:0] comment_char;
        logic [7:0] separator_char;
    } tok_cfg_t;

    // One result word.
    typedef struct packed {
        line_result_t     line_result;
        logic             line_done;
        logic             is_string;
        logic [ARG_W-1:0] arg_index;
        char_role_t       char_role;
    } tok_result_t;

    // Space, tab, LF, CR, VT and FF count as blanks.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9) || (c == 8'd10) ||
               (c == 8'd13) || (c == 8'd11) || (c == 8'd12);
    endfunction

    function automatic line_result_t kind_to_result(input line_kind_t k);
        line_result_t r;
        unique case (k)
            KIND_NONE:  r = RES_EMPTY;
            KIND_INSTR: r = RES_INSTR;
            KIND_LABEL: r = RES_LABEL;
            KIND_DIR:   r = RES_DIR;
            default:    r = RES_EMPTY;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/asm_tok_step.sv
// Per-byte next-state and result logic of the line tokenizer.
`default_nettype none
module asm_tok_step (
    input  wire logic [7:0]                   chr,
    input  wire asm_tok_pkg::tok_state_t      cur,
    input  wire asm_tok_pkg::tok_cfg_t        cfg,
    input  wire logic [asm_tok_pkg::ARG_W-1:0] arg_limit,
    output asm_tok_pkg::tok_state_t           nxt,
    output asm_tok_pkg::tok_result_t          res
);

    logic eol;
    logic cmt;
    logic blank;
    logic [asm_tok_pkg::ARG_W-1:0] cnt_inc;

    assign eol   = (chr == asm_tok_pkg::CHR_EOL);
    assign cmt   = (chr == cfg.comment_char) &&
                   (cur.parse != asm_tok_pkg::ST_STRING) &&
                   (cur.parse != asm_tok_pkg::ST_SKIP);
    assign blank = asm_tok_pkg::is_blank(chr);
    assign cnt_inc = (cur.arg_cnt < arg_limit) ? cur.arg_cnt + 1'b1 : cur.arg_cnt;

    // Next state.
    always_comb begin
        nxt = cur;
        priority if (cur.parse == asm_tok_pkg::ST_SKIP || eol || cmt) begin
            nxt = cur;
        end else begin
            unique case (cur.parse)
                asm_tok_pkg::ST_WAIT_START: begin
                    if (chr == asm_tok_pkg::CHR_DOT) begin
                        nxt.kind  = asm_tok_pkg::KIND_DIR;
                        nxt.parse = asm_tok_pkg::ST_STATEMENT;
                    end else if (!blank) begin
                        nxt.parse = asm_tok_pkg::ST_STATEMENT;
                    end
                end
                asm_tok_pkg::ST_STATEMENT: begin
                    if (chr == asm_tok_pkg::CHR_COLON) begin
                        nxt.kind  = asm_tok_pkg::KIND_LABEL;
                        nxt.parse = asm_tok_pkg::ST_EXPECT_END;
                    end else if (blank) begin
                        if (cur.kind == asm_tok_pkg::KIND_NONE) begin
                            nxt.kind = asm_tok_pkg::KIND_INSTR;
                        end
                        nxt.parse = asm_tok_pkg::ST_WAIT_ARG;
                    end
                end
                asm_tok_pkg::ST_EXPECT_END: begin
                    if (!blank) begin
                        nxt.parse = asm_tok_pkg::ST_SKIP;
                    end
                end
                asm_tok_pkg::ST_WAIT_ARG: begin
                    if (chr == asm_tok_pkg::CHR_QUOTE) begin
                        nxt.parse = asm_tok_pkg::ST_STRING;
                    end else if (!blank) begin
                        nxt.parse = asm_tok_pkg::ST_ARG;
                    end
                end
                asm_tok_pkg::ST_ARG: begin
                    if (chr == cfg.separator_char) begin
                        nxt.arg_cnt = cnt_inc;
                        nxt.parse   = asm_tok_pkg::ST_WAIT_ARG;
                    end else if (blank) begin
                        nxt.parse = asm_tok_pkg::ST_WAIT_SEP;
                    end
                end
                asm_tok_pkg::ST_STRING: begin
                    if (chr == asm_tok_pkg::CHR_QUOTE) begin
                        nxt.parse = asm_tok_pkg::ST_WAIT_SEP;
                    end
                end
                asm_tok_pkg::ST_WAIT_SEP: begin
                    if (chr == cfg.separator_char) begin
                        nxt.arg_cnt = cnt_inc;
                        nxt.parse   = asm_tok_pkg::ST_WAIT_ARG;
                    end else if (!blank) begin
                        nxt.parse = asm_tok_pkg::ST_SKIP;
                    end
                end
                default: nxt = cur;
            endcase
        end

        // End of line restarts the machine; a comment skips the rest.
        priority if (eol) begin
            nxt.parse   = asm_tok_pkg::ST_WAIT_START;
            nxt.kind    = asm_tok_pkg::KIND_NONE;
            nxt.arg_cnt = '0;
        end else if (cmt) begin
            nxt.parse = asm_tok_pkg::ST_SKIP;
        end else begin
            nxt.parse = nxt.parse;
        end
    end

    // Result word.
    always_comb begin
        res.char_role   = asm_tok_pkg::ROLE_SKIP;
        res.arg_index   = cur.arg_cnt;
        res.is_string   = 1'b0;
        res.line_done   = 1'b0;
        res.line_result = asm_tok_pkg::RES_EMPTY;
        priority if (cur.parse == asm_tok_pkg::ST_SKIP) begin
            res.char_role = eol ? asm_tok_pkg::ROLE_TERM : asm_tok_pkg::ROLE_IGN;
        end else if (eol || cmt) begin
            res.char_role = asm_tok_pkg::ROLE_TERM;
            res.line_done = 1'b1;
            if (cur.parse == asm_tok_pkg::ST_WAIT_START) begin
                res.line_result = asm_tok_pkg::RES_EMPTY;
            end else if (cur.parse == asm_tok_pkg::ST_STATEMENT &&
                         cur.kind == asm_tok_pkg::KIND_NONE) begin
                res.line_result = asm_tok_pkg::RES_INSTR;
            end else begin
                res.line_result = asm_tok_pkg::kind_to_result(cur.kind);
            end
            res.is_string = (cur.parse == asm_tok_pkg::ST_STRING);
        end else begin
            unique case (cur.parse)
                asm_tok_pkg::ST_WAIT_START: begin
                    if (!blank) begin
                        res.char_role = asm_tok_pkg::ROLE_SSTART;
                    end
                end
                asm_tok_pkg::ST_STATEMENT: begin
                    if (chr != asm_tok_pkg::CHR_COLON && !blank) begin
                        res.char_role = asm_tok_pkg::ROLE_SBODY;
                    end
                end
                asm_tok_pkg::ST_EXPECT_END, asm_tok_pkg::ST_WAIT_SEP: begin
                    if (!blank && !(cur.parse == asm_tok_pkg::ST_WAIT_SEP &&
                                    chr == cfg.separator_char)) begin
                        res.char_role   = asm_tok_pkg::ROLE_IGN;
                        res.line_done   = 1'b1;
                        res.line_result = asm_tok_pkg::RES_ERROR;
                    end
                end
                asm_tok_pkg::ST_WAIT_ARG: begin
                    if (chr == asm_tok_pkg::CHR_QUOTE) begin
                        res.char_role = asm_tok_pkg::ROLE_ASTART;
                        res.is_string = 1'b1;
                    end else if (!blank) begin
                        res.char_role = asm_tok_pkg::ROLE_ASTART;
                    end
                end
                asm_tok_pkg::ST_ARG: begin
                    if (chr != cfg.separator_char && !blank) begin
                        res.char_role = asm_tok_pkg::ROLE_ABODY;
                    end
                end
                asm_tok_pkg::ST_STRING: begin
                    res.is_string = 1'b1;
                    if (chr != asm_tok_pkg::CHR_QUOTE) begin
                        res.char_role = asm_tok_pkg::ROLE_ABODY;
                    end
                end
                default: res.char_role = asm_tok_pkg::ROLE_IGN;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/asm_line_tokenizer.sv
// Top level of the assembly line tokenizer: input register, step logic, result register.
// An accepted word waits in the input register, and its result goes to the result register.
// One word per cycle unless the result stream stalls; the parse state feeds back in one step.
// A stalled result word holds the next word in the input register, and s_tready stays low
// until the result is taken; at most two words wait inside the block.
// Reset (aresetn low, synchronous) empties both registers, returns the machine to waiting
// for a statement start and restores comment and separator bytes to ';' and ','.
`default_nettype none
module asm_line_tokenizer #(
    parameter int MAX_ARGS = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] chr
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [2:0] char_role, [6:3] arg_index, [7] is_string,
                                        // [8] line_done, [11:9] line_result, [15:12] zero
);

    // The argument counter saturates at MAX_ARGS or at the largest 4-bit value.
    localparam logic [asm_tok_pkg::ARG_W-1:0] ARG_LIMIT =
        (MAX_ARGS > int'(asm_tok_pkg::ARG_CAP)) ? asm_tok_pkg::ARG_CAP
                                                 : asm_tok_pkg::ARG_W'(MAX_ARGS);

    logic                     in_valid_reg, in_valid_next;
    logic [7:0]               in_chr_reg, in_chr_next;
    logic                     out_valid_reg, out_valid_next;
    asm_tok_pkg::tok_result_t out_data_reg, out_data_next;
    asm_tok_pkg::tok_state_t  state_reg, state_next;
    asm_tok_pkg::tok_cfg_t    cfg_reg, cfg_next;

    asm_tok_pkg::tok_state_t  step_state;
    asm_tok_pkg::tok_result_t step_result;

    logic s_fire;
    logic advance;

    // The held word moves to the result register whenever that register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    asm_tok_step u_step (
        .chr       (in_chr_reg),
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .arg_limit (ARG_LIMIT),
        .nxt       (step_state),
        .res       (step_result)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_chr_next    = in_chr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        state_next     = state_reg;
        cfg_next       = cfg_reg;

        if (s_fire) begin
            in_valid_next = 1'b1;
            in_chr_next   = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = step_result;
            state_next     = step_state;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_we) begin
            unique case (cfg_index)
                asm_tok_pkg::CFG_COMMENT:   cfg_next.comment_char   = cfg_data;
                asm_tok_pkg::CFG_SEPARATOR: cfg_next.separator_char = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.parse        <= asm_tok_pkg::ST_WAIT_START;
            state_reg.kind         <= asm_tok_pkg::KIND_NONE;
            state_reg.arg_cnt      <= '0;
            cfg_reg.comment_char   <= asm_tok_pkg::COMMENT_RESET;
            cfg_reg.separator_char <= asm_tok_pkg::SEPARATOR_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        in_chr_reg   <= in_chr_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

endmodule
`default_nettype wire

>>> rtl/asm_tok_checker.sv
// Port-level checker for the assembly line tokenizer, bound to the top level.
`default_nettype none
module asm_tok_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic        cfg_index,
    input wire logic [7:0]  cfg_data,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // A stalled result word holds until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The block comes out of reset with nothing to deliver.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A line class is only reported on the word that decides the line.
    a_result_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> m_tdata[11:9] == asm_tok_pkg::RES_EMPTY)
        else $error("line result without line done");

    // An unexpected-char verdict always lands on an ignored byte.
    a_error_role: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] && m_tdata[11:9] == asm_tok_pkg::RES_ERROR
        |-> m_tdata[2:0] == asm_tok_pkg::ROLE_IGN)
        else $error("error verdict on a byte that is not ignored");

    // A decided line is tagged terminator unless it is an error.
    a_done_role: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] && m_tdata[11:9] != asm_tok_pkg::RES_ERROR
        |-> m_tdata[2:0] == asm_tok_pkg::ROLE_TERM)
        else $error("decided line not on a terminator byte");

endmodule

bind asm_line_tokenizer asm_tok_props u_asm_tok_checker (.*);
`default_nettype wire

>>> tb/asm_tok_checker.sv
// Checker for the assembly line tokenizer: tracks the parse of every accepted byte and compares tags.
module asm_tok_checker
    import asm_tok_pkg::*;
#(
    parameter int MAX_ARGS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] chr
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [2:0] char_role, [6:3] arg_index, [7] is_string,
                                    // [8] line_done, [11:9] line_result, [15:12] zero
    output int          fail_count,
    output int          pending
);

    // The argument index stops at the smaller of MAX_ARGS and the counter's own top.
    localparam logic [ARG_W-1:0] ARG_TOP = ARG_W'((MAX_ARGS > 15) ? 15 : MAX_ARGS);

    tok_state_t  line_st;
    tok_cfg_t    cfg_copy;
    tok_result_t tags_due[$];
    int          mismatches = 0;
    int          results_seen = 0;

    function automatic logic space_byte(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0B || c == 8'h0C;
    endfunction

    // Tags one byte and moves the line parse forward.
    task automatic tag_byte(input logic [7:0] c, output tok_result_t r);
        parse_state_t st;
        logic         eol;
        logic         cmt;
        st  = line_st.parse;
        eol = (c == CHR_EOL);
        cmt = (c == cfg_copy.comment_char) && (st != ST_STRING) && (st != ST_SKIP);
        r = '{line_result: RES_EMPTY, line_done: 1'b0, is_string: 1'b0,
              arg_index: line_st.arg_cnt, char_role: ROLE_SKIP};
        if (st == ST_SKIP) begin
            r.char_role = eol ? ROLE_TERM : ROLE_IGN;
        end else if (eol || cmt) begin
            r.char_role = ROLE_TERM;
            r.line_done = 1'b1;
            if (st == ST_WAIT_START)
                r.line_result = RES_EMPTY;
            else if (st == ST_STATEMENT && line_st.kind == KIND_NONE)
                r.line_result = RES_INSTR;
            else
                r.line_result = line_result_t'({1'b0, line_st.kind});
            r.is_string = (st == ST_STRING);
        end else begin
            case (st)
                ST_WAIT_START: if (!space_byte(c)) begin
                    r.char_role   = ROLE_SSTART;
                    line_st.parse = ST_STATEMENT;
                    if (c == CHR_DOT)
                        line_st.kind = KIND_DIR;
                end
                ST_STATEMENT: if (c == CHR_COLON) begin
                    line_st.kind  = KIND_LABEL;
                    line_st.parse = ST_EXPECT_END;
                end else if (space_byte(c)) begin
                    if (line_st.kind == KIND_NONE)
                        line_st.kind = KIND_INSTR;
                    line_st.parse = ST_WAIT_ARG;
                end else begin
                    r.char_role = ROLE_SBODY;
                end
                ST_EXPECT_END: if (!space_byte(c)) begin
                    r.char_role   = ROLE_IGN;
                    r.line_done   = 1'b1;
                    r.line_result = RES_ERROR;
                    line_st.parse = ST_SKIP;
                end
                ST_WAIT_ARG: if (c == CHR_QUOTE) begin
                    r.char_role   = ROLE_ASTART;
                    r.is_string   = 1'b1;
                    line_st.parse = ST_STRING;
                end else if (!space_byte(c)) begin
                    r.char_role   = ROLE_ASTART;
                    line_st.parse = ST_ARG;
                end
                ST_ARG: if (c == cfg_copy.separator_char) begin
                    if (line_st.arg_cnt < ARG_TOP)
                        line_st.arg_cnt = line_st.arg_cnt + 1'b1;
                    line_st.parse = ST_WAIT_ARG;
                end else if (space_byte(c)) begin
                    line_st.parse = ST_WAIT_SEP;
                end else begin
                    r.char_role = ROLE_ABODY;
                end
                ST_STRING: begin
                    r.is_string = 1'b1;
                    if (c == CHR_QUOTE)
                        line_st.parse = ST_WAIT_SEP;
                    else
                        r.char_role = ROLE_ABODY;
                end
                ST_WAIT_SEP: if (c == cfg_copy.separator_char) begin
                    if (line_st.arg_cnt < ARG_TOP)
                        line_st.arg_cnt = line_st.arg_cnt + 1'b1;
                    line_st.parse = ST_WAIT_ARG;
                end else if (!space_byte(c)) begin
                    r.char_role   = ROLE_IGN;
                    r.line_done   = 1'b1;
                    r.line_result = RES_ERROR;
                    line_st.parse = ST_SKIP;
                end
                default: ;
            endcase
        end
        if (eol)
            line_st = '{ST_WAIT_START, KIND_NONE, '0};
        else if (cmt)
            line_st.parse = ST_SKIP;
    endtask

    always @(posedge aclk) begin
        tok_result_t want;
        tok_result_t got;
        if (!aresetn) begin
            line_st  = '{ST_WAIT_START, KIND_NONE, '0};
            cfg_copy = '{COMMENT_RESET, SEPARATOR_RESET};
            tags_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = tok_result_t'(m_tdata[11:0]);
                results_seen++;
                if (tags_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tag word %0d arrived with no byte waiting: data %h",
                                 results_seen, m_tdata);
                end else begin
                    want = tags_due.pop_front();
                    if (got.char_role !== want.char_role || got.arg_index !== want.arg_index ||
                        got.is_string !== want.is_string || got.line_done !== want.line_done ||
                        got.line_result !== want.line_result || m_tdata[15:12] !== 4'd0) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("tag word %0d: expected role %0d arg %0d str %0b done %0b ",
                                   results_seen, want.char_role, want.arg_index,
                                   want.is_string, want.line_done);
                            $write("line %0d, got role %0d arg %0d str %0b done %0b ",
                                   want.line_result, got.char_role, got.arg_index,
                                   got.is_string, got.line_done);
                            $display("line %0d pad %h", got.line_result, m_tdata[15:12]);
                        end
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_COMMENT)
                    cfg_copy.comment_char = cfg_data;
                else
                    cfg_copy.separator_char = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                tag_byte(s_tdata, want);
                tags_due = {tags_due, want};
            end
        end
        pending    <= tags_due.size();
        fail_count <= mismatches;
    end

endmodule

>>> tb/tb_top.sv
// Top of the tokenizer testbench: clock, reset, byte stimulus, result back-pressure and verdict.
module tb_top;
    import asm_tok_pkg::*;

    // The block is built with its default argument ceiling; the checker must agree.
    localparam int ARGS_MAX = 15;
    // Far above the slowest correct run of the directed lines and the six random phases.
    localparam int CYCLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_COMMENT;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;      // [7:0] chr
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;              // [2:0] char_role, [6:3] arg_index, [7] is_string,
                                       // [8] line_done, [11:9] line_result, [15:12] zero
    int          fail_count;
    int          pending;

    // Idling controls, in percent per cycle, changed from phase to phase.
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          cycles = 0;

    // The comment and separator bytes the block currently uses; the line builder needs them.
    logic [7:0]  cur_comment = COMMENT_RESET;
    logic [7:0]  cur_sep = SEPARATOR_RESET;

    // Bytes of the line being built, zero terminator included.
    logic [7:0]  line_q[$];
    int          phase_bytes;

    asm_line_tokenizer #(.MAX_ARGS(ARGS_MAX)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    asm_tok_checker #(.MAX_ARGS(ARGS_MAX)) watcher (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver decides afresh every cycle whether it takes a tag word.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one byte, possibly after some idle cycles, and returns at the edge that takes it.
    // Valid stays high from one word to the next unless an idle cycle is drawn.
    task automatic send_word(input logic [7:0] c);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_word(line_q[i]);
    endtask

    // Stops offering bytes until the checker has seen every tag word it expects.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Writes the comment register and then the separator register; the block must be idle.
    task automatic set_config(input logic [7:0] comment_b, input logic [7:0] sep_b);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COMMENT;
        cfg_data  <= comment_b;
        @(posedge aclk);
        cfg_index <= CFG_SEPARATOR;
        cfg_data  <= sep_b;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        cur_comment  = comment_b;
        cur_sep      = sep_b;
    endtask

    // Appends one byte to the line being built.
    task automatic put_byte(input logic [7:0] b);
        line_q = {line_q, b};
    endtask

    task automatic add_blanks(input int n);
        logic [7:0] blank_set [6];
        blank_set = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
        repeat (n) put_byte(blank_set[$urandom_range(5)]);
    endtask

    // Identifier-like text: letters, digits and underscore.
    task automatic add_word(input int n);
        int k;
        repeat (n) begin
            k = $urandom_range(36);
            if (k < 26)
                put_byte(8'h61 + 8'(k));
            else if (k < 36)
                put_byte(8'h30 + 8'(k - 26));
            else
                put_byte(8'h5F);
        end
    endtask

    // Builds one line. Most lines are well formed statements with random content so that
    // the argument and string states get plenty of traffic; the rest are empty lines,
    // labels, raw noise, and statements broken by a stray token.
    task automatic build_line();
        int         pick;
        int         nargs;
        logic [7:0] b;
        line_q.delete();
        pick = $urandom_range(99);
        if (pick < 8) begin
            add_blanks($urandom_range(2));
        end else if (pick < 16) begin
            repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(1, 255)));
        end else if (pick < 26) begin
            add_blanks($urandom_range(2));
            if ($urandom_range(3) == 0)
                put_byte(CHR_DOT);
            add_word($urandom_range(1, 6));
            put_byte(CHR_COLON);
            add_blanks($urandom_range(2));
            // Any byte after the label colon other than a blank, a comment or the end of line is an error.
            if ($urandom_range(4) == 0)
                add_word(1);
        end else begin
            add_blanks($urandom_range(2));
            if ($urandom_range(9) < 3)
                put_byte(CHR_DOT);
            add_word($urandom_range(1, 6));
            // Now and then enough arguments to drive the index into saturation.
            nargs = ($urandom_range(19) == 0) ? $urandom_range(15, 19) : $urandom_range(4);
            if (nargs > 0)
                add_blanks($urandom_range(1, 2));
            for (int a = 0; a < nargs; a++) begin
                if (a > 0) begin
                    add_blanks($urandom_range(1));
                    put_byte(cur_sep);
                    add_blanks($urandom_range(1));
                end
                if ($urandom_range(3) == 0) begin
                    put_byte(CHR_QUOTE);
                    repeat ($urandom_range(5)) begin
                        do b = 8'($urandom_range(1, 255)); while (b == CHR_QUOTE);
                        put_byte(b);
                    end
                    // Sometimes the string is left open until the end of the line.
                    if ($urandom_range(9) != 0)
                        put_byte(CHR_QUOTE);
                end else begin
                    add_word($urandom_range(1, 5));
                end
            end
            // After a closed argument, a second token after a blank, with no separator, is an error.
            if ($urandom_range(14) == 0) begin
                put_byte(8'h20);
                add_word(1);
            end
            add_blanks($urandom_range(1));
        end
        if ($urandom_range(3) == 0) begin
            put_byte(cur_comment);
            repeat ($urandom_range(3)) put_byte(8'($urandom_range(1, 255)));
        end
        put_byte(CHR_EOL);
    endtask

    initial begin
        logic [7:0] comment_b;
        logic [7:0] sep_b;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines under the reset settings: an empty line, a label after a blank,
        // a directive word closed by a colon and followed by junk, a quoted argument
        // holding 0xFF and the comment byte then junk after the closing quote, a separator
        // met while waiting for an argument followed by a comment, and a string cut off by
        // the end of the line.
        line_q = '{CHR_EOL,
                   8'h20, "x", CHR_COLON, CHR_EOL,
                   CHR_DOT, "d", CHR_COLON, "y", CHR_EOL,
                   "a", 8'h20, CHR_QUOTE, 8'hFF, COMMENT_RESET, CHR_QUOTE, 8'h09, "b", CHR_EOL,
                   "i", 8'h20, "b", SEPARATOR_RESET, SEPARATOR_RESET, "c", COMMENT_RESET, "z",
                   CHR_EOL,
                   "a", 8'h20, CHR_QUOTE, CHR_EOL};
        send_line();

        // Random phases. Each one drains the block, picks new settings and an idling mode,
        // then streams random lines until at least a hundred bytes have gone.
        for (int p = 0; p < 6; p++) begin
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 60;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 60;
                end
                default: begin
                    idle_pct  = 10;
                    stall_pct = 10;
                end
            endcase
            wait_idle();
            // Reset values, both extremes, settings where the comment or the separator byte
            // collides with another special byte, and finally a random pair.
            case (p)
                0: begin
                    comment_b = COMMENT_RESET;
                    sep_b     = SEPARATOR_RESET;
                end
                1: begin
                    comment_b = 8'h00;
                    sep_b     = 8'h00;
                end
                2: begin
                    comment_b = 8'hFF;
                    sep_b     = 8'hFF;
                end
                3: begin
                    comment_b = CHR_COLON;
                    sep_b     = 8'h20;
                end
                4: begin
                    comment_b = CHR_QUOTE;
                    sep_b     = CHR_DOT;
                end
                default: begin
                    comment_b = 8'($urandom_range(255));
                    sep_b     = 8'($urandom_range(255));
                end
            endcase
            set_config(comment_b, sep_b);
            phase_bytes = 0;
            while (phase_bytes < 100) begin
                build_line();
                send_line();
                phase_bytes += line_q.size();
            end
        end

        // Let every outstanding tag word arrive, then keep watching for strays before the verdict.
        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
